[src/afm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afm_pkg
// Shared types, constants and tables of the array field magnitude block.
// ----------------------------------------------------------------------------
package afm_pkg;

  localparam int AFM_FRAC_BITS = 16;

  localparam logic [31:0] AFM_AMP_RESET  = 32'd65536;
  localparam logic [31:0] AFM_WAVE_RESET = 32'd411775;

  // 2^32 / (2*pi), rounded: radians to 2^-32 turn
  localparam logic [29:0] AFM_TURN_PER_RAD = 30'd683565276;
  // gain-corrected 1.0 in Q4.30
  localparam logic [33:0] AFM_CORDIC_ONE   = 34'd652032874;
  localparam int          AFM_CORDIC_STEPS = 30;
  localparam int          AFM_ROOT_STEPS   = 33;
  localparam int          AFM_DIV_STEPS    = 64;

  // register indexes of the configuration port
  localparam logic AFM_REG_AMPLITUDE   = 1'b0;
  localparam logic AFM_REG_WAVE_NUMBER = 1'b1;

  typedef enum logic [3:0] {
    MUL_NONE = 4'd0,
    MUL_SQX  = 4'd1,
    MUL_SQY  = 4'd2,
    MUL_SQZ  = 4'd3,
    MUL_PH   = 4'd4,
    MUL_TU0  = 4'd5,
    MUL_TU1  = 4'd6,
    MUL_NC   = 4'd7,
    MUL_NS   = 4'd8,
    MUL_RELL = 4'd9,
    MUL_REHL = 4'd10,
    MUL_REHH = 4'd11,
    MUL_IMLL = 4'd12,
    MUL_IMHL = 4'd13,
    MUL_IMHH = 4'd14
  } mul_op_t;

  typedef struct packed {
    logic       load_in;
    mul_op_t    mul_op;
    logic       sqrt_init;
    logic       sqrt_mag;
    logic       sqrt_step;
    logic       a_load;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] idx;
    logic       div_step;
    logic       sum_acc;
    logic       hit_set;
    logic       out_load;
  } afm_cmd_t;

  typedef struct packed {
    logic dist_zero;
    logic last;
    logic out_busy;
  } afm_sts_t;

  // arctangent table in 2^-32 turn units
  function automatic logic [29:0] afm_atan(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/afm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afm_ctrl
// Sequencer: steps the shared multiplier, root, CORDIC and divider units.
// ----------------------------------------------------------------------------
module afm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire afm_pkg::afm_sts_t sts,
  output afm_pkg::afm_cmd_t      cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_ZCHK  = 13'b0000000000100,
    S_ROOTD = 13'b0000000001000,
    S_PHASE = 13'b0000000010000,
    S_CORD  = 13'b0000000100000,
    S_NUM   = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_ACC   = 13'b0000100000000,
    S_LAST  = 13'b0001000000000,
    S_MAG   = 13'b0010000000000,
    S_ROOTM = 13'b0100000000000,
    S_OUTW  = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 7'd1;
    cmd       = '0;
    cmd.mul_op = afm_pkg::MUL_NONE;
    cmd.idx   = cnt_r[4:0];
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        unique case (cnt_r[1:0])
          2'd0: cmd.mul_op = afm_pkg::MUL_SQX;
          2'd1: cmd.mul_op = afm_pkg::MUL_SQY;
          2'd2: cmd.mul_op = afm_pkg::MUL_SQZ;
          default: state_nxt = S_ZCHK;
        endcase
      end
      S_ZCHK: begin
        cnt_nxt = '0;
        if (sts.dist_zero) begin
          cmd.hit_set = 1'b1;
          state_nxt   = S_LAST;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_ROOTD;
        end
      end
      S_ROOTD: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 7'(afm_pkg::AFM_ROOT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        // the product is registered before use; wait where the next op depends on it
        unique case (cnt_r[2:0])
          3'd0: cmd.a_load = 1'b1;
          3'd1: cmd.mul_op = afm_pkg::MUL_PH;
          3'd3: cmd.mul_op = afm_pkg::MUL_TU0;
          3'd4: cmd.mul_op = afm_pkg::MUL_TU1;
          3'd6: begin
            cmd.cordic_init = 1'b1;
            cnt_nxt         = '0;
            state_nxt       = S_CORD;
          end
          default: ;
        endcase
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        if (cnt_r == 7'(afm_pkg::AFM_CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        unique case (cnt_r[1:0])
          2'd0: cmd.mul_op = afm_pkg::MUL_NC;
          2'd1: cmd.mul_op = afm_pkg::MUL_NS;
          default: begin
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 7'(afm_pkg::AFM_DIV_STEPS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = S_LAST;
      end
      S_LAST: begin
        cnt_nxt   = '0;
        state_nxt = sts.last ? S_MAG : S_IDLE;
      end
      S_MAG: begin
        unique case (cnt_r[2:0])
          3'd0: cmd.mul_op = afm_pkg::MUL_RELL;
          3'd1: cmd.mul_op = afm_pkg::MUL_REHL;
          3'd2: cmd.mul_op = afm_pkg::MUL_REHH;
          3'd3: cmd.mul_op = afm_pkg::MUL_IMLL;
          3'd4: cmd.mul_op = afm_pkg::MUL_IMHL;
          3'd5: cmd.mul_op = afm_pkg::MUL_IMHH;
          3'd6: ;
          default: begin
            cmd.sqrt_init = 1'b1;
            cmd.sqrt_mag  = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_ROOTM;
          end
        endcase
      end
      S_ROOTM: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == 7'(afm_pkg::AFM_ROOT_STEPS - 1)) begin
          state_nxt = S_OUTW;
        end
      end
      S_OUTW: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a waiting result");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> (state_r == S_SQ && cnt_r == 7'd0))
    else $error("accepted item did not start the distance pass");

  a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sqrt_step && (cmd.cordic_step || cmd.div_step)))
    else $error("iterative units stepped together");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < 7'(afm_pkg::AFM_DIV_STEPS)))
    else $error("divider ran past its last step");

endmodule
`default_nettype wire

[src/afm_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afm_dp
// Datapath: shared multiplier, square root, CORDIC, dual-lane divider, sums.
// ----------------------------------------------------------------------------
module afm_dp #(
  parameter int FRAC_BITS = afm_pkg::AFM_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire afm_pkg::afm_cmd_t cmd,
  output afm_pkg::afm_sts_t      sts,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [31:0]       in_obs_x,
  input  wire logic [31:0]       in_obs_y,
  input  wire logic [31:0]       in_obs_z,
  input  wire logic [31:0]       in_elem_x,
  input  wire logic [31:0]       in_elem_y,
  input  wire logic [31:0]       in_elem_z,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_magnitude,
  output logic                   out_coincident
);

  localparam int U_LO      = 2 * FRAC_BITS;
  localparam int DEN_SHIFT = 30 - FRAC_BITS;

  logic [31:0]  amp_r, wave_r;
  logic [32:0]  dx_r, dy_r, dz_r;
  logic         last_r;
  afm_pkg::mul_op_t mul_op_r;
  logic [32:0]  mul_a, mul_b;
  logic [65:0]  prod_r;
  logic [127:0] acc_r;
  logic [64:0]  p_r;
  logic [32:0]  a_r;
  logic [65:0]  rad_r;
  logic [37:0]  rem_r;
  logic [32:0]  root_r;
  logic         sat_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [1:0]   q_r;
  logic signed [33:0] c_v, s_v;
  logic [32:0]  cabs, sabs;
  logic         neg_c_r, neg_s_r;
  logic [63:0]  qc_r, qs_r, remc_r, rems_r;
  logic [63:0]  den;
  logic signed [63:0] sum_re_r, sum_im_r;
  logic         hit_r;
  logic [63:0]  re_abs, im_abs;
  logic [31:0]  mag_r;
  logic         coin_r;
  logic         out_valid_r;

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  assign re_abs = sum_re_r[63] ? 64'(-sum_re_r) : 64'(sum_re_r);
  assign im_abs = sum_im_r[63] ? 64'(-sum_im_r) : 64'(sum_im_r);

  // quadrant map of the CORDIC result
  always_comb begin
    unique case (q_r)
      2'd0: begin c_v = x_r;  s_v = y_r;  end
      2'd1: begin c_v = -y_r; s_v = x_r;  end
      2'd2: begin c_v = -x_r; s_v = -y_r; end
      default: begin c_v = y_r; s_v = -x_r; end
    endcase
  end

  assign cabs = c_v[33] ? 33'(-c_v) : 33'(c_v);
  assign sabs = s_v[33] ? 33'(-s_v) : 33'(s_v);
  assign den  = 64'({31'b0, a_r} << DEN_SHIFT);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      afm_pkg::MUL_SQX:  begin mul_a = dx_r; mul_b = dx_r; end
      afm_pkg::MUL_SQY:  begin mul_a = dy_r; mul_b = dy_r; end
      afm_pkg::MUL_SQZ:  begin mul_a = dz_r; mul_b = dz_r; end
      afm_pkg::MUL_PH:   begin mul_a = {1'b0, wave_r}; mul_b = {1'b0, a_r[31:0]}; end
      afm_pkg::MUL_TU0:  begin
        mul_a = {1'b0, p_r[31:0]};
        mul_b = {3'b0, afm_pkg::AFM_TURN_PER_RAD};
      end
      afm_pkg::MUL_TU1:  begin
        mul_a = p_r[64:32];
        mul_b = {3'b0, afm_pkg::AFM_TURN_PER_RAD};
      end
      afm_pkg::MUL_NC:   begin mul_a = {1'b0, amp_r}; mul_b = cabs; end
      afm_pkg::MUL_NS:   begin mul_a = {1'b0, amp_r}; mul_b = sabs; end
      afm_pkg::MUL_RELL: begin mul_a = {1'b0, re_abs[31:0]};  mul_b = {1'b0, re_abs[31:0]}; end
      afm_pkg::MUL_REHL: begin mul_a = {1'b0, re_abs[63:32]}; mul_b = {1'b0, re_abs[31:0]}; end
      afm_pkg::MUL_REHH: begin mul_a = {1'b0, re_abs[63:32]}; mul_b = {1'b0, re_abs[63:32]}; end
      afm_pkg::MUL_IMLL: begin mul_a = {1'b0, im_abs[31:0]};  mul_b = {1'b0, im_abs[31:0]}; end
      afm_pkg::MUL_IMHL: begin mul_a = {1'b0, im_abs[63:32]}; mul_b = {1'b0, im_abs[31:0]}; end
      afm_pkg::MUL_IMHH: begin mul_a = {1'b0, im_abs[63:32]}; mul_b = {1'b0, im_abs[63:32]}; end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r       <= afm_pkg::AFM_AMP_RESET;
      wave_r      <= afm_pkg::AFM_WAVE_RESET;
      mul_op_r    <= afm_pkg::MUL_NONE;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == afm_pkg::AFM_REG_AMPLITUDE) begin
          amp_r <= cfg_data;
        end else begin
          wave_r <= cfg_data;
        end
      end
      mul_op_r <= cmd.mul_op;
      if (cmd.hit_set) begin
        hit_r <= 1'b1;
      end
      if (cmd.sum_acc) begin
        sum_re_r <= sat_add(sum_re_r, neg_c_r ? -$signed(qc_r) : $signed(qc_r));
        sum_im_r <= sat_add(sum_im_r, neg_s_r ? $signed(qs_r) : -$signed(qs_r));
      end
      if (cmd.out_load) begin
        sum_re_r    <= '0;
        sum_im_r    <= '0;
        hit_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic [37:0] remsh;
    logic [37:0] trial;
    logic [63:0] rc, rs;
    logic        gec, ges;
    logic signed [33:0] dxs, dys;

    if (cmd.load_in) begin
      dx_r   <= abs_diff(in_obs_x, in_elem_x);
      dy_r   <= abs_diff(in_obs_y, in_elem_y);
      dz_r   <= abs_diff(in_obs_z, in_elem_z);
      last_r <= in_last;
    end

    prod_r <= mul_a * mul_b;

    // act on the registered product of the op held in mul_op_r
    unique case (mul_op_r)
      afm_pkg::MUL_SQX, afm_pkg::MUL_TU0, afm_pkg::MUL_RELL:
        acc_r <= {62'b0, prod_r};
      afm_pkg::MUL_SQY, afm_pkg::MUL_SQZ, afm_pkg::MUL_IMLL:
        acc_r <= acc_r + {62'b0, prod_r};
      afm_pkg::MUL_PH:
        p_r <= {1'b0, prod_r[63:0]} + (a_r[32] ? {1'b0, wave_r, 32'b0} : 65'b0);
      afm_pkg::MUL_TU1:
        acc_r <= acc_r + {30'b0, prod_r, 32'b0};
      afm_pkg::MUL_NC: begin
        qc_r    <= prod_r[63:0];
        remc_r  <= '0;
        neg_c_r <= c_v[33];
      end
      afm_pkg::MUL_NS: begin
        qs_r    <= prod_r[63:0];
        rems_r  <= '0;
        neg_s_r <= s_v[33];
      end
      afm_pkg::MUL_REHL, afm_pkg::MUL_IMHL:
        acc_r <= acc_r + {29'b0, prod_r, 33'b0};
      afm_pkg::MUL_REHH, afm_pkg::MUL_IMHH:
        acc_r <= acc_r + {prod_r[63:0], 64'b0};
      default: ;
    endcase

    // square root, one result bit a step
    if (cmd.sqrt_init) begin
      rad_r  <= cmd.sqrt_mag ? {2'b0, acc_r[63:0]} : acc_r[65:0];
      sat_r  <= cmd.sqrt_mag && (acc_r[127:64] != 64'b0);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      remsh = {rem_r[35:0], rad_r[65:64]};
      trial = {3'b0, root_r, 2'b01};
      if (remsh >= trial) begin
        rem_r  <= remsh - trial;
        root_r <= {root_r[31:0], 1'b1};
      end else begin
        rem_r  <= remsh;
        root_r <= {root_r[31:0], 1'b0};
      end
      rad_r <= {rad_r[63:0], 2'b00};
    end

    if (cmd.a_load) begin
      a_r <= root_r;
    end

    // CORDIC rotation
    if (cmd.cordic_init) begin
      x_r <= $signed(afm_pkg::AFM_CORDIC_ONE);
      y_r <= '0;
      z_r <= $signed({3'b0, acc_r[U_LO +: 30]});
      q_r <= acc_r[U_LO + 30 +: 2];
    end else if (cmd.cordic_step) begin
      dxs = y_r >>> cmd.idx;
      dys = x_r >>> cmd.idx;
      if (!z_r[32]) begin
        x_r <= x_r - dxs;
        y_r <= y_r + dys;
        z_r <= z_r - $signed({3'b0, afm_pkg::afm_atan(cmd.idx)});
      end else begin
        x_r <= x_r + dxs;
        y_r <= y_r - dys;
        z_r <= z_r + $signed({3'b0, afm_pkg::afm_atan(cmd.idx)});
      end
    end

    // restoring divider, both lanes over the same divisor
    if (cmd.div_step) begin
      rc  = {remc_r[62:0], qc_r[63]};
      rs  = {rems_r[62:0], qs_r[63]};
      gec = (rc >= den);
      ges = (rs >= den);
      remc_r <= gec ? rc - den : rc;
      rems_r <= ges ? rs - den : rs;
      qc_r   <= {qc_r[62:0], gec};
      qs_r   <= {qs_r[62:0], ges};
    end

    if (cmd.out_load) begin
      mag_r  <= sat_r ? 32'hFFFF_FFFF : root_r[31:0];
      coin_r <= hit_r;
    end
  end

  assign sts.dist_zero = (acc_r[65:0] == 66'b0);
  assign sts.last      = last_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_magnitude  = mag_r;
  assign out_coincident = coin_r;

endmodule
`default_nettype wire

[src/array_field_magnitude_at_point_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// array_field_magnitude_at_point_top
// Field magnitude of an antenna array at one observation point.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An element item occupies the block from
// acceptance through 33 square root steps for the distance, 30 CORDIC steps
// for sine and cosine and 64 divider steps, plus the multiplier passes of
// the shared 33 x 33 unit. An element lying on the point skips those steps.
// The item marked last then takes the magnitude (six partial products and a
// second 33 step root) before its result enters the output register; the
// next item is accepted while that result still waits. Configuration writes
// take effect at once and are always ready.
module array_field_magnitude_at_point_top #(
  parameter int FRAC_BITS = afm_pkg::AFM_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_obs_x,
  input  wire logic [31:0] in_obs_y,
  input  wire logic [31:0] in_obs_z,
  input  wire logic [31:0] in_elem_x,
  input  wire logic [31:0] in_elem_y,
  input  wire logic [31:0] in_elem_z,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_magnitude,
  output logic             out_coincident
);

  afm_pkg::afm_cmd_t cmd;
  afm_pkg::afm_sts_t sts;

  assign cfg_ready = 1'b1;

  afm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_obs_x       (in_obs_x),
    .in_obs_y       (in_obs_y),
    .in_obs_z       (in_obs_z),
    .in_elem_x      (in_elem_x),
    .in_elem_y      (in_elem_y),
    .in_elem_z      (in_elem_z),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_magnitude  (out_magnitude),
    .out_coincident (out_coincident)
  );

endmodule
`default_nettype wire

[sim/afm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afm_checker
// Watches the configuration, input and result channels of the array field
// magnitude block. Predicts each magnitude and coincident flag from the items
// it sees accepted and compares them, in order, with the results delivered.
// ----------------------------------------------------------------------------
module afm_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [31:0] in_obs_x,
  input  wire logic [31:0] in_obs_y,
  input  wire logic [31:0] in_obs_z,
  input  wire logic [31:0] in_elem_x,
  input  wire logic [31:0] in_elem_y,
  input  wire logic [31:0] in_elem_z,
  input  wire logic        in_last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] out_magnitude,
  input  wire logic        out_coincident,
  output int               fail_count,
  output int               pending_count,
  output int               result_count,
  output int               coincident_count,
  output int               saturated_count
);
  import afm_pkg::*;

  localparam int FB = AFM_FRAC_BITS;

  typedef struct packed {
    logic [31:0] magnitude;
    logic        coincident;
  } field_result_t;

  field_result_t    field_q[$];
  logic [31:0]      amp_reg;
  logic [31:0]      wave_reg;
  logic signed [63:0] acc_re;
  logic signed [63:0] acc_im;
  logic             hit;

  assign pending_count = field_q.size();

  function automatic logic [65:0] root_floor(input logic [131:0] v);
    logic [131:0] rem;
    logic [131:0] root;
    logic [131:0] trial;
    rem  = 0;
    root = 0;
    for (int i = 65; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 132'd3);
      trial = (root << 2) | 132'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 132'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[65:0];
  endfunction

  // rotate the in-quadrant remainder, then map by quadrant
  task automatic rotate_turn(input logic [31:0] u, output logic signed [63:0] c,
                             output logic signed [63:0] s);
    logic signed [63:0] x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    z = {34'd0, u[29:0]};
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - $signed({34'd0, afm_atan(5'(i))});
      end else begin
        x = x + dx; y = y - dy; z = z + $signed({34'd0, afm_atan(5'(i))});
      end
    end
    case (u[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [63:0] scaled_term(input logic signed [63:0] v,
                                                     input logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v < 0 ? 64'(-v) : 64'(v);
    q   = 64'({32'd0, amp_reg} * mag) / den;
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] w;
    w = 65'(a) + 65'(b);
    if (w > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (w < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return w[63:0];
  endfunction

  task automatic add_element();
    logic signed [32:0] dx, dy, dz;
    logic [65:0]        sq;
    logic [63:0]        elem_dist;
    logic [127:0]       turns;
    logic signed [63:0] c, s;
    dx = $signed({in_obs_x[31], in_obs_x}) - $signed({in_elem_x[31], in_elem_x});
    dy = $signed({in_obs_y[31], in_obs_y}) - $signed({in_elem_y[31], in_elem_y});
    dz = $signed({in_obs_z[31], in_obs_z}) - $signed({in_elem_z[31], in_elem_z});
    sq = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
    if (sq == 0) begin
      hit = 1'b1;
    end else begin
      elem_dist = 64'(root_floor(132'(sq)));
      turns     = 128'(wave_reg) * 128'(elem_dist) * 128'(AFM_TURN_PER_RAD);
      rotate_turn(turns[2*FB +: 32], c, s);
      acc_re = add_clamped(acc_re, scaled_term(c, elem_dist << (30 - FB)));
      acc_im = add_clamped(acc_im, -scaled_term(s, elem_dist << (30 - FB)));
    end
  endtask

  task automatic close_point();
    logic [63:0]   re, im;
    logic [128:0]  pw;
    field_result_t r;
    re = acc_re < 0 ? 64'(-acc_re) : 64'(acc_re);
    im = acc_im < 0 ? 64'(-acc_im) : 64'(acc_im);
    pw = 129'(re) * 129'(re) + 129'(im) * 129'(im);
    if (pw[128:64] != 0) begin
      r.magnitude = 32'hFFFF_FFFF;
    end else begin
      r.magnitude = 32'(root_floor(132'(pw[63:0])));
      if (root_floor(132'(pw[63:0])) > 66'hFFFF_FFFF) r.magnitude = 32'hFFFF_FFFF;
    end
    r.coincident = hit;
    field_q.push_back(r);
    acc_re = 0;
    acc_im = 0;
    hit    = 1'b0;
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      amp_reg  <= AFM_AMP_RESET;
      wave_reg <= AFM_WAVE_RESET;
      acc_re = 0;
      acc_im = 0;
      hit    = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == AFM_REG_AMPLITUDE) amp_reg <= cfg_data;
        else wave_reg <= cfg_data;
      end
      if (out_valid && out_ready) begin
        result_count++;
        if (field_q.size() == 0) begin
          report("unexpected result", out_magnitude, 32'd0);
        end else begin
          if (out_magnitude != field_q[0].magnitude)
            report("magnitude", out_magnitude, field_q[0].magnitude);
          if (out_coincident != field_q[0].coincident)
            report("coincident", 32'(out_coincident), 32'(field_q[0].coincident));
          if (field_q[0].coincident) coincident_count++;
          if (field_q[0].magnitude == 32'hFFFF_FFFF) saturated_count++;
          void'(field_q.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        add_element();
        if (in_last) close_point();
      end
    end
  end

  initial begin
    fail_count       = 0;
    result_count     = 0;
    coincident_count = 0;
    saturated_count  = 0;
  end
endmodule

[sim/array_field_magnitude_at_point_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_field_magnitude_at_point_top_tb
// Drives element items in groups per observation point under several
// amplitude and wave number settings, with bursty input and a stalling
// receiver; the checker predicts and compares every magnitude result.
// ----------------------------------------------------------------------------
module array_field_magnitude_at_point_top_tb;
  import afm_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_obs_x, in_obs_y, in_obs_z;
  logic [31:0] in_elem_x, in_elem_y, in_elem_z;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_magnitude;
  logic        out_coincident;

  int fail_count, pending_count, result_count, coincident_count, saturated_count;
  int item_count;
  bit hold_off;
  bit sending_done;

  array_field_magnitude_at_point_top DUT (.*);

  afm_checker u_checker (.*);

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: own stall pattern, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else if (sending_done) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  task automatic send_item(input logic [31:0] ox, oy, oz, ex, ey, ez,
                           input logic lst);
    in_valid  <= 1'b1;
    in_obs_x  <= ox; in_obs_y  <= oy; in_obs_z  <= oz;
    in_elem_x <= ex; in_elem_y <= ey; in_elem_z <= ez;
    in_last   <= lst;
    do @(posedge clk); while (!in_ready);
    item_count++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 200)) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      2: return 32'($signed(16'($urandom())) * 65536) >>> 6;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed(12'($urandom())) <<< 12);
    endcase
  endfunction

  // one observation point with a few elements; some lie on the point
  task automatic send_point(input int n);
    logic [31:0] ox, oy, oz;
    logic [31:0] ex, ey, ez;
    int          burst;
    ox = pick_coord(); oy = pick_coord(); oz = pick_coord();
    burst = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        ex = ox; ey = oy; ez = oz;
      end else begin
        ex = pick_coord(); ey = pick_coord(); ez = pick_coord();
      end
      // a stray point change now and then
      if ($urandom_range(0, 19) == 0) ox = pick_coord();
      send_item(ox, oy, oz, ex, ey, ez, i == n - 1);
      if (--burst == 0) begin
        if ($urandom_range(0, 2) != 0) pause_sender();
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    logic [31:0] amps[5];
    logic [31:0] waves[5];
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= AFM_REG_AMPLITUDE;
    cfg_data  <= 32'd0;
    in_valid  <= 1'b0;
    in_obs_x  <= 0; in_obs_y <= 0; in_obs_z <= 0;
    in_elem_x <= 0; in_elem_y <= 0; in_elem_z <= 0;
    in_last   <= 1'b0;
    hold_off  = 1'b0;
    sending_done = 1'b0;
    item_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, coincidence, single and multi element points
    send_item(0, 0, 0, 0, 0, 0, 1'b1);
    send_item(0, 0, 0, 32'h0001_0000, 0, 0, 1'b1);
    send_item(0, 0, 0, 0, 0, 1, 1'b1);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_item(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
    send_item(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0000, 0, 1'b1);
    send_item(5, 5, 5, 5, 5, 5, 1'b0);
    send_item(5, 5, 5, 6, 5, 5, 1'b1);
    settle();
    write_reg(AFM_REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(AFM_REG_WAVE_NUMBER, 32'd0);
    for (int i = 0; i < 8; i++) send_item(0, 0, 0, 0, 0, 1, i == 7);
    send_item(0, 0, 0, 0, 1, 0, 1'b0);
    send_item(0, 0, 0, 0, 0, 0, 1'b1);
    settle();
    write_reg(AFM_REG_WAVE_NUMBER, 32'hFFFF_FFFF);
    write_reg(AFM_REG_AMPLITUDE, 32'd0);
    send_item(0, 0, 0, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 1'b1);
    send_item(1, 2, 3, 32'h0100_0000, 7, 9, 1'b1);

    // random phases over a spread of settings, extremes first
    amps  = '{32'd0, 32'hFFFF_FFFF, AFM_AMP_RESET, 32'd1, 32'h0123_4567};
    waves = '{32'hFFFF_FFFF, 32'd0, AFM_WAVE_RESET, 32'd1, 32'h0004_0000};
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph < 5) begin
        write_reg(AFM_REG_AMPLITUDE, amps[ph]);
        write_reg(AFM_REG_WAVE_NUMBER, waves[ph]);
      end else begin
        write_reg(AFM_REG_AMPLITUDE, $urandom());
        write_reg(AFM_REG_WAVE_NUMBER, $urandom());
      end
      if (ph == 2) begin
        // hold the receiver off while items keep coming so the block backs up
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
          for (int k = 0; k < 8; k++) send_point(1);
        join
      end
      while (item_count < 260 * (ph + 1)) send_point($urandom_range(1, 6));
    end

    in_valid <= 1'b0;
    sending_done = 1'b1;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d element items; %0d points checked, %0d with a coincident element,",
             item_count, result_count, coincident_count);
    $display("%0d saturated magnitudes, amplitude and wave number swept to extremes",
             saturated_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
src/afm_pkg.sv
src/afm_ctrl.sv
src/afm_dp.sv
src/array_field_magnitude_at_point_top.sv
sim/afm_checker.sv
sim/array_field_magnitude_at_point_top_tb.sv
